// File: design/tcpq_pkg.sv
`default_nettype none
package tcpq_pkg;

  localparam int TCPQ_DEPTH = 4;

  localparam int AGE_W    = 7;
  localparam int TICKET_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [AGE_W-1:0]    AGE_THRESHOLD_RST  = 7'd60;
  localparam logic [TICKET_W-1:0] NORMAL_START_RST    = 16'd1;
  localparam logic [TICKET_W-1:0] PREFERRED_START_RST = 16'd100;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_REMOVED = 2'd2,
    ST_EMPTY   = 2'd3
  } tcpq_status_t;

  typedef enum logic [1:0] {
    REG_AGE_THRESHOLD   = 2'd0,
    REG_NORMAL_START    = 2'd1,
    REG_PREFERRED_START = 2'd2
  } tcpq_reg_t;

  typedef struct packed {
    logic [AGE_W-1:0] age_threshold;
    logic             normal_reload;
    logic [TICKET_W-1:0] normal_start;
    logic             preferred_reload;
    logic [TICKET_W-1:0] preferred_start;
  } tcpq_cfg_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
  } tcpq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } tcpq_stat_t;

endpackage
`default_nettype wire

// File: design/tcpq_if.sv
`default_nettype none
interface tcpq_req_if import tcpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [AGE_W-1:0] age;

  modport source (output valid, output mode, output age, input ready);
  modport sink (input valid, input mode, input age, output ready);
endinterface

interface tcpq_rsp_if import tcpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TICKET_W-1:0] ticket;
  logic                from_preferred;

  modport source (output valid, output status, output ticket, output from_preferred,
                  input ready);
  modport sink (input valid, input status, input ticket, input from_preferred,
                output ready);
endinterface
`default_nettype wire

// File: design/tcpq_cfg.sv
`default_nettype none
module tcpq_cfg import tcpq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output tcpq_cfg_t                  cfg
);

  logic [AGE_W-1:0]    age_threshold;
  logic [TICKET_W-1:0] normal_start;
  logic [TICKET_W-1:0] preferred_start;
  logic                wr_en;
  tcpq_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = tcpq_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold   <= AGE_THRESHOLD_RST;
      normal_start    <= NORMAL_START_RST;
      preferred_start <= PREFERRED_START_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_AGE_THRESHOLD:   age_threshold   <= pwdata[AGE_W-1:0];
        REG_NORMAL_START:    normal_start    <= pwdata[TICKET_W-1:0];
        REG_PREFERRED_START: preferred_start <= pwdata[TICKET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AGE_THRESHOLD:   prdata = {{(CFG_DATA_W-AGE_W){1'b0}}, age_threshold};
      REG_NORMAL_START:    prdata = {{(CFG_DATA_W-TICKET_W){1'b0}}, normal_start};
      REG_PREFERRED_START: prdata = {{(CFG_DATA_W-TICKET_W){1'b0}}, preferred_start};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.age_threshold    = age_threshold;
    cfg.normal_start     = pwdata[TICKET_W-1:0];
    cfg.preferred_start  = pwdata[TICKET_W-1:0];
    cfg.normal_reload    = wr_en && (reg_sel == REG_NORMAL_START);
    cfg.preferred_reload = wr_en && (reg_sel == REG_PREFERRED_START);
  end

endmodule
`default_nettype wire

// File: design/tcpq_ctrl.sv
`default_nettype none
module tcpq_ctrl import tcpq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tcpq_stat_t stat,
  output tcpq_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = (state == S_IDLE) & in_valid;
    cmd.lookup  = (state == S_LOOKUP);
    cmd.execute = (state == S_EXEC) & ~stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/tcpq_datapath.sv
`default_nettype none
module tcpq_datapath import tcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = TCPQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcpq_cmd_t        cmd,
  output tcpq_stat_t            stat,
  input  wire tcpq_cfg_t        cfg,
  input  wire logic             in_mode,
  input  wire logic [AGE_W-1:0] in_age,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [TICKET_W-1:0]   out_ticket,
  output logic                  out_from_preferred
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [TICKET_W-1:0] normal_mem    [QUEUE_DEPTH];
  logic [TICKET_W-1:0] preferred_mem [QUEUE_DEPTH];

  logic                mode;
  logic [AGE_W-1:0]    age;
  logic [TICKET_W-1:0] normal_rd;
  logic [TICKET_W-1:0] preferred_rd;

  logic [PW-1:0]       normal_head;
  logic [PW-1:0]       normal_tail;
  logic [CW-1:0]       normal_count;
  logic [PW-1:0]       preferred_head;
  logic [PW-1:0]       preferred_tail;
  logic [CW-1:0]       preferred_count;
  logic [TICKET_W-1:0] normal_next_ticket;
  logic [TICKET_W-1:0] preferred_next_ticket;

  logic                is_pref;
  logic                normal_push;
  logic                preferred_push;
  logic                normal_pop;
  logic                preferred_pop;
  tcpq_status_t        status_next;
  logic [TICKET_W-1:0] ticket_next;
  logic                pref_next;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    advance = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign stat.out_busy = out_valid & ~out_ready;
  assign is_pref       = (age >= cfg.age_threshold);

  always_comb begin
    normal_push    = 1'b0;
    preferred_push = 1'b0;
    normal_pop     = 1'b0;
    preferred_pop  = 1'b0;
    status_next    = ST_EMPTY;
    ticket_next    = '0;
    pref_next      = 1'b0;
    if (mode == MODE_INSERT) begin
      pref_next = is_pref;
      if (is_pref) begin
        if (preferred_count != FULL_CNT) begin
          preferred_push = 1'b1;
          status_next    = ST_ADDED;
          ticket_next    = preferred_next_ticket;
        end else begin
          status_next = ST_FULL;
        end
      end else begin
        if (normal_count != FULL_CNT) begin
          normal_push = 1'b1;
          status_next = ST_ADDED;
          ticket_next = normal_next_ticket;
        end else begin
          status_next = ST_FULL;
        end
      end
    end else begin
      priority if (preferred_count != '0) begin
        preferred_pop = 1'b1;
        pref_next     = 1'b1;
        status_next   = ST_REMOVED;
        ticket_next   = preferred_rd;
      end else if (normal_count != '0) begin
        normal_pop  = 1'b1;
        status_next = ST_REMOVED;
        ticket_next = normal_rd;
      end else begin
        status_next = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= in_mode;
      age  <= in_age;
    end
    if (cmd.lookup) begin
      normal_rd    <= normal_mem[normal_head];
      preferred_rd <= preferred_mem[preferred_head];
    end
    if (cmd.execute && normal_push) normal_mem[normal_tail] <= normal_next_ticket;
    if (cmd.execute && preferred_push) begin
      preferred_mem[preferred_tail] <= preferred_next_ticket;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_head           <= '0;
      normal_tail           <= '0;
      normal_count          <= '0;
      preferred_head        <= '0;
      preferred_tail        <= '0;
      preferred_count       <= '0;
      normal_next_ticket    <= NORMAL_START_RST;
      preferred_next_ticket <= PREFERRED_START_RST;
    end else begin
      if (cfg.normal_reload) normal_next_ticket <= cfg.normal_start;
      if (cfg.preferred_reload) preferred_next_ticket <= cfg.preferred_start;
      if (cmd.execute) begin
        if (normal_push) begin
          normal_tail        <= advance(normal_tail);
          normal_count       <= normal_count + 1'b1;
          normal_next_ticket <= normal_next_ticket + 1'b1;
        end
        if (preferred_push) begin
          preferred_tail        <= advance(preferred_tail);
          preferred_count       <= preferred_count + 1'b1;
          preferred_next_ticket <= preferred_next_ticket + 1'b1;
        end
        if (normal_pop) begin
          normal_head  <= advance(normal_head);
          normal_count <= normal_count - 1'b1;
        end
        if (preferred_pop) begin
          preferred_head  <= advance(preferred_head);
          preferred_count <= preferred_count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status         <= status_next;
      out_ticket         <= ticket_next;
      out_from_preferred <= pref_next;
    end
  end

endmodule
`default_nettype wire

// File: design/two_class_priority_ticket_queue.sv
`default_nettype none
// Two-class strict-priority ticket queue. Each request transaction either inserts a person
// into the normal or preferred queue by age, drawing the next ticket of that class, or
// removes the next ticket, preferred first. Every request returns exactly one response
// transaction. The accepting edge captures the request, the lookup state then registers the
// read of both queue heads, and the execute state updates the queues and loads the response
// register. The block takes no new request until the execute state of the last one is done,
// and the execute state waits while an earlier response still sits untaken in the response
// register. No clearing pass is needed after reset.
module two_class_priority_ticket_queue import tcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = TCPQ_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tcpq_req_if.sink                   in_ch,
  tcpq_rsp_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  tcpq_cfg_t  cfg;
  tcpq_cmd_t  cmd;
  tcpq_stat_t stat;

  tcpq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg),
    .in_mode            (in_ch.mode),
    .in_age             (in_ch.age),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_ticket         (out_ch.ticket),
    .out_from_preferred (out_ch.from_preferred)
  );

endmodule
`default_nettype wire

// File: design/tcpq_checker.sv
`default_nettype none
module tcpq_checker import tcpq_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [TICKET_W-1:0] out_ticket,
  input wire logic                out_from_preferred
);

  // A held response must not change until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_ticket)
      && $stable(out_from_preferred))
    else $error("response changed while stalled");

  // Requests are processed one at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A response must never appear in the cycle after the request acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !(out_valid && $rose(out_valid)))
    else $error("response appeared too early");

  // Full and empty responses carry no ticket.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY) |-> out_ticket == '0)
    else $error("ticket nonzero on a full or empty response");

  // An empty response reports neither queue.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> !out_from_preferred)
    else $error("empty response marked preferred");

endmodule

bind two_class_priority_ticket_queue tcpq_checker u_tcpq_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_ticket         (out_ch.ticket),
  .out_from_preferred (out_ch.from_preferred)
);
`default_nettype wire
